// ===== hdl/rsd_pkg.sv =====
// Shared types and constants for the report stream deframer.
package rsd_pkg;

   localparam int REPORT_BYTES_DEF = 64;

   localparam logic [7:0] MARK_START = 8'h3F;  // '?'
   localparam logic [7:0] MARK_HASH  = 8'h23;  // '#'

   localparam int POS_HASH_A = 1;
   localparam int POS_HASH_B = 2;
   localparam int POS_TAG_HI = 3;
   localparam int POS_TAG_LO = 4;
   localparam int HDR_END    = 9;

   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_EMPTY_DONE = 2'd1,
      KIND_BAD_START  = 2'd2,
      KIND_BAD_CONT   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [15:0] message_tag;
      logic        last_flag;
   } result_type;

endpackage

// ===== hdl/rsd_req_if.sv =====
// Input channel: one raw report byte per item.
interface rsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hdl/rsd_rsp_if.sv =====
// Result channel: payload byte, tag, kind and last mark per item.
interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [15:0] message_tag;
   logic        last_flag;

   modport source (output valid, output kind, output payload_byte, output message_tag,
                   output last_flag, input ready);
   modport sink   (input valid, input kind, input payload_byte, input message_tag,
                   input last_flag, output ready);
endinterface

// ===== hdl/rsd_parser.sv =====
// Per-byte deframing state and result decode.
module rsd_parser #(
   parameter int REPORT_BYTES = rsd_pkg::REPORT_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   output logic               hit,
   output rsd_pkg::result_type result
);
   import rsd_pkg::*;

   localparam int POS_W = $clog2(REPORT_BYTES);
   localparam logic [POS_W-1:0] P_HASH_A = POS_W'(POS_HASH_A);
   localparam logic [POS_W-1:0] P_HASH_B = POS_W'(POS_HASH_B);
   localparam logic [POS_W-1:0] P_TAG_HI = POS_W'(POS_TAG_HI);
   localparam logic [POS_W-1:0] P_TAG_LO = POS_W'(POS_TAG_LO);
   localparam logic [POS_W-1:0] P_HDR_END = POS_W'(HDR_END);
   localparam logic [POS_W-1:0] P_LAST = POS_W'(REPORT_BYTES - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             in_msg_ff, in_msg_in;
   logic             discard_ff, discard_in;
   logic [15:0]      tag_ff, tag_in;
   logic [31:0]      len_ff, len_in;
   logic [31:0]      rem_ff, rem_in;

   always_comb begin
      pos_in     = pos_ff;
      in_msg_in  = in_msg_ff;
      discard_in = discard_ff;
      tag_in     = tag_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      hit        = 1'b0;
      result     = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, message_tag: 16'h0000,
                     last_flag: 1'b0};

      if (!discard_ff) begin
         if (!in_msg_ff) begin
            if (pos_ff == '0) begin
               if (data_byte != MARK_START) begin
                  hit         = 1'b1;
                  result.kind = KIND_BAD_START;
                  discard_in  = 1'b1;
               end
            end else if (pos_ff == P_HASH_A || pos_ff == P_HASH_B) begin
               if (data_byte != MARK_HASH) begin
                  hit         = 1'b1;
                  result.kind = KIND_BAD_START;
                  discard_in  = 1'b1;
               end
            end else if (pos_ff == P_TAG_HI) begin
               tag_in = {data_byte, 8'h00};
            end else if (pos_ff == P_TAG_LO) begin
               tag_in = {tag_ff[15:8], data_byte};
            end else if (pos_ff < P_HDR_END) begin
               len_in = {len_ff[23:0], data_byte};
               if (pos_ff == P_HDR_END - 1'b1) begin
                  if (len_in == 32'd0) begin
                     hit                = 1'b1;
                     result.kind        = KIND_EMPTY_DONE;
                     result.message_tag = tag_ff;
                     result.last_flag   = 1'b1;
                     discard_in         = 1'b1;
                  end else begin
                     rem_in    = len_in;
                     in_msg_in = 1'b1;
                  end
               end
            end
         end else if (pos_ff == '0) begin
            if (data_byte != MARK_START) begin
               hit         = 1'b1;
               result.kind = KIND_BAD_CONT;
               in_msg_in   = 1'b0;
               discard_in  = 1'b1;
            end
         end else begin
            rem_in              = rem_ff - 32'd1;
            hit                 = 1'b1;
            result.payload_byte = data_byte;
            result.message_tag  = tag_ff;
            result.last_flag    = (rem_in == 32'd0);
            if (rem_in == 32'd0) begin
               in_msg_in  = 1'b0;
               discard_in = 1'b1;
            end
         end
      end

      if (pos_ff == P_LAST) begin
         pos_in     = '0;
         discard_in = 1'b0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         in_msg_ff  <= 1'b0;
         discard_ff <= 1'b0;
         tag_ff     <= '0;
         len_ff     <= '0;
         rem_ff     <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         in_msg_ff  <= in_msg_in;
         discard_ff <= discard_in;
         tag_ff     <= tag_in;
         len_ff     <= len_in;
         rem_ff     <= rem_in;
      end
   end

endmodule

// ===== hdl/report_stream_deframer_unit.sv =====
// Report stream deframer: recovers framed messages from fixed-size byte reports.
//
// req_chan carries one raw report byte per item; reports of REPORT_BYTES bytes
// arrive back to back. The first report of a message starts "?##", a 16-bit
// big-endian tag and a 32-bit big-endian length; continuation reports start '?'.
// rsp_chan carries at most one item per input byte: a payload byte with tag and
// last mark, an empty-message done, or a bad start / continuation marker error.
// Bytes that give no result (markers, header, padding, dropped bytes) are
// consumed silently.
// A result is registered and appears on rsp_chan the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a held result stalls; the single state
// update per byte is the whole loop; a result register separates the channels.
// While rsp_chan stalls with a result held, req_chan stays ready only if the
// held result is taken in that cycle.
// Reset clears all framing state; the block then awaits a first report at
// byte 0 and holds no result.
module report_stream_deframer_unit #(
   parameter int REPORT_BYTES = rsd_pkg::REPORT_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   rsd_req_if.sink  req_chan,
   rsd_rsp_if.source rsp_chan
);
   import rsd_pkg::*;

   logic       accept;
   logic       hit;
   result_type result;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   rsd_parser #(
      .REPORT_BYTES(REPORT_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .hit       (hit),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      if (accept && hit) begin
         rsp_valid_in = 1'b1;
         res_in       = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = res_ff.kind;
   assign rsp_chan.payload_byte = res_ff.payload_byte;
   assign rsp_chan.message_tag  = res_ff.message_tag;
   assign rsp_chan.last_flag    = res_ff.last_flag;

endmodule
